### src/ledfs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the coordinate-to-strip mapping of the LED
// matrix frame store. No dependencies.
package ledfs_pkg;

   localparam int MaxColumns = 32;
   localparam int MaxRows    = 32;
   localparam int StoreDepth = MaxColumns * MaxRows;
   localparam int AddrW      = 10;
   localparam int AreaW      = 11;
   localparam int DimW       = 6;
   localparam int PosW       = 5;
   localparam int StepW      = 6;
   localparam int CoordW     = 8;
   localparam int PixW       = 24;
   localparam int OpW        = 3;
   localparam int CsrAddrW   = 4;
   localparam int CsrDataW   = 32;

   typedef enum logic [OpW-1:0] {
      OP_WRITE_XY     = 3'd0,
      OP_READ_XY      = 3'd1,
      OP_READ_STRIP   = 3'd2,
      OP_SCROLL_LEFT  = 3'd3,
      OP_SCROLL_RIGHT = 3'd4,
      OP_SCROLL_UP    = 3'd5,
      OP_SCROLL_DOWN  = 3'd6,
      OP_CLEAR        = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_SERP   = 2'd2,
      REG_COLMAJ = 2'd3
   } reg_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_CLEAR,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic [DimW-1:0] width;
      logic [DimW-1:0] height;
      logic            serpentine;
      logic            column_major;
   } cfg_type;

   typedef struct packed {
      logic [AddrW-1:0] mapped_index;
      logic             out_of_range;
      logic [PixW-1:0]  pixel_out;
   } result_type;

   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] waddr;
      logic [PixW-1:0]  wdata;
      logic [AddrW-1:0] raddr;
   } ram_cmd_type;

   // zero acts as one, anything above the limit acts as the limit
   function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] value,
                                                input logic [DimW-1:0] limit);
      logic [DimW-1:0] res;
      if (value == '0) res = DimW'(1);
      else if (value > limit) res = limit;
      else res = value;
      return res;
   endfunction

   // x < w and y < h expected
   function automatic logic [AddrW-1:0] map_xy(input logic [PosW-1:0] x,
                                                input logic [PosW-1:0] y,
                                                input logic [DimW-1:0] w,
                                                input logic [DimW-1:0] h,
                                                input logic serp,
                                                input logic colmaj);
      logic [PosW-1:0]  major;
      logic [PosW-1:0]  minor;
      logic [DimW-1:0]  len;
      logic             rev;
      logic [PosW-1:0]  offs;
      logic [AreaW-1:0] prod;
      if (colmaj) begin
         major = PosW'(w - DimW'(1) - {1'b0, x});
         minor = y;
         len   = h;
         rev   = serp & ~x[0];
      end else begin
         major = y;
         minor = x;
         len   = w;
         rev   = serp & y[0];
      end
      offs = rev ? PosW'(len - DimW'(1) - {1'b0, minor}) : minor;
      prod = AreaW'(major) * AreaW'(len);
      return AddrW'(prod + AreaW'(offs));
   endfunction

endpackage

### src/ledfs_req_if.sv
`timescale 1ns / 1ps
// Request channel of the frame store: valid/ready plus one pixel command.
// Depends on ledfs_pkg for field widths.
interface ledfs_req_if;
   logic                          valid;
   logic                          ready;
   logic [ledfs_pkg::OpW-1:0]     opcode;
   logic [ledfs_pkg::CoordW-1:0]  x_pos;
   logic [ledfs_pkg::CoordW-1:0]  y_pos;
   logic [ledfs_pkg::AddrW-1:0]   strip_position;
   logic [ledfs_pkg::PixW-1:0]    pixel_in;

   modport source (output valid, opcode, x_pos, y_pos, strip_position, pixel_in,
                   input ready);
   modport sink (input valid, opcode, x_pos, y_pos, strip_position, pixel_in,
                 output ready);
endinterface

### src/ledfs_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the frame store: valid/ready plus one result.
// Depends on ledfs_pkg for field widths.
interface ledfs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ledfs_pkg::AddrW-1:0] mapped_index;
   logic                        out_of_range;
   logic [ledfs_pkg::PixW-1:0]  pixel_out;

   modport source (output valid, mapped_index, out_of_range, pixel_out, input ready);
   modport sink (input valid, mapped_index, out_of_range, pixel_out, output ready);
endinterface

### src/ledfs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ledfs_ram #(
   parameter int Width = 24,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rd_data = rdata_ff;
endmodule

### src/ledfs_csr.sv
`timescale 1ns / 1ps
// APB-style register block holding the matrix geometry and layout.
// Depends on ledfs_pkg.
module ledfs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ledfs_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [ledfs_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [ledfs_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                             csr_pready,
   output ledfs_pkg::cfg_type               cfg
);
   import ledfs_pkg::*;

   logic [DimW-1:0] width_ff;
   logic [DimW-1:0] height_ff;
   logic            serp_ff;
   logic            colmaj_ff;
   logic            wr_en;
   reg_type         reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DimW'(MaxColumns);
         height_ff <= DimW'(MaxRows);
         serp_ff   <= 1'b0;
         colmaj_ff <= 1'b0;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_WIDTH:  width_ff  <= csr_pwdata[DimW-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[DimW-1:0];
            REG_SERP:   serp_ff   <= csr_pwdata[0];
            REG_COLMAJ: colmaj_ff <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_WIDTH:  csr_prdata = CsrDataW'(width_ff);
         REG_HEIGHT: csr_prdata = CsrDataW'(height_ff);
         REG_SERP:   csr_prdata = CsrDataW'(serp_ff);
         REG_COLMAJ: csr_prdata = CsrDataW'(colmaj_ff);
      endcase
   end

   assign cfg = '{width: width_ff, height: height_ff,
                  serpentine: serp_ff, column_major: colmaj_ff};
endmodule

### src/ledfs_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer: decodes requests, drives the pixel RAM for pixel access,
// clear and scroll sweeps, and holds the response register.
// Depends on ledfs_pkg and the request/response interfaces.
module ledfs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   ledfs_req_if.sink                   req_if,
   ledfs_rsp_if.source                 rsp_if,
   input  ledfs_pkg::cfg_type          cfg,
   output ledfs_pkg::ram_cmd_type      ram_cmd,
   input  logic [ledfs_pkg::PixW-1:0]  rd_data
);
   import ledfs_pkg::*;

   state_type        state_ff, state_in;
   logic [AddrW-1:0] cnt_ff;
   logic [StepW-1:0] step_ff;
   logic [PosW-1:0]  line_ff;
   logic             vert_ff;
   logic             rev_ff;
   logic [PixW-1:0]  tmp_ff;
   logic [AddrW-1:0] addr_d1_ff;
   logic [AddrW-1:0] addr_d2_ff;
   result_type       pend_ff;
   logic             rsp_valid_ff;
   result_type       rsp_data_ff;

   logic [DimW-1:0]  eff_w, eff_h;
   logic [AreaW-1:0] area;
   op_type           req_op;
   logic             accept;
   logic             slot_free;
   logic             xy_oor, strip_oor;
   logic [AddrW-1:0] xy_idx, read_idx;
   logic [DimW-1:0]  line_len, line_cnt;
   logic [StepW-1:0] kpos;
   logic [PosW-1:0]  sx, sy;
   logic [AddrW-1:0] scroll_addr;
   logic             step_last, line_last;
   logic             res_valid;
   result_type       res;

   assign eff_w  = eff_dim(cfg.width, DimW'(MaxColumns));
   assign eff_h  = eff_dim(cfg.height, DimW'(MaxRows));
   assign area   = AreaW'(eff_w) * AreaW'(eff_h);

   assign req_op    = op_type'(req_if.opcode);
   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept    = req_if.valid & req_if.ready;
   assign slot_free = ~rsp_valid_ff | rsp_if.ready;

   assign xy_oor = (req_if.x_pos >= CoordW'(eff_w)) || (req_if.y_pos >= CoordW'(eff_h));
   assign xy_idx = map_xy(req_if.x_pos[PosW-1:0], req_if.y_pos[PosW-1:0], eff_w, eff_h,
                          cfg.serpentine, cfg.column_major);
   assign strip_oor = AreaW'(req_if.strip_position) >= area;
   assign read_idx  = (req_op == OP_READ_STRIP) ? req_if.strip_position : xy_idx;

   // scroll walks one line at a time; position k is read at step k and
   // written with the pixel of position k+1, the first pixel wraps to the end
   assign line_len    = vert_ff ? eff_h : eff_w;
   assign line_cnt    = vert_ff ? eff_w : eff_h;
   assign kpos        = rev_ff ? StepW'(line_len - DimW'(1) - step_ff) : step_ff;
   assign sx          = vert_ff ? line_ff : kpos[PosW-1:0];
   assign sy          = vert_ff ? kpos[PosW-1:0] : line_ff;
   assign scroll_addr = map_xy(sx, sy, eff_w, eff_h, cfg.serpentine, cfg.column_major);
   assign step_last   = (step_ff == StepW'(line_len + DimW'(1)));
   assign line_last   = ({1'b0, line_ff} == line_cnt - DimW'(1));

   // RAM commands and finished results
   always_comb begin
      ram_cmd   = '{we: 1'b0, waddr: '0, wdata: '0, raddr: scroll_addr};
      res_valid = 1'b0;
      res       = '0;
      unique case (state_ff)
         ST_INIT: begin
            ram_cmd.we    = 1'b1;
            ram_cmd.waddr = cnt_ff;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_WRITE_XY: begin
                     ram_cmd.we    = ~xy_oor;
                     ram_cmd.waddr = xy_idx;
                     ram_cmd.wdata = req_if.pixel_in;
                     res_valid     = 1'b1;
                     res.out_of_range = xy_oor;
                     res.mapped_index = xy_oor ? '0 : xy_idx;
                  end
                  OP_READ_XY: begin
                     ram_cmd.raddr    = xy_idx;
                     res_valid        = xy_oor;
                     res.out_of_range = xy_oor;
                  end
                  OP_READ_STRIP: begin
                     ram_cmd.raddr    = req_if.strip_position;
                     res_valid        = strip_oor;
                     res.out_of_range = strip_oor;
                  end
                  OP_SCROLL_LEFT, OP_SCROLL_RIGHT, OP_SCROLL_UP, OP_SCROLL_DOWN,
                  OP_CLEAR: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            res_valid     = 1'b1;
            res           = pend_ff;
            res.pixel_out = rd_data;
         end
         ST_SCROLL: begin
            if (step_ff >= StepW'(2)) begin
               ram_cmd.we    = 1'b1;
               ram_cmd.waddr = addr_d2_ff;
               ram_cmd.wdata = step_last ? tmp_ff : rd_data;
            end
            res_valid = step_last & line_last;
         end
         ST_CLEAR: begin
            ram_cmd.we    = 1'b1;
            ram_cmd.waddr = cnt_ff;
            res_valid     = ({1'b0, cnt_ff} == area - AreaW'(1));
         end
         ST_HOLD: begin
            res_valid = 1'b1;
            res       = pend_ff;
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      priority if (res_valid) begin
         state_in = slot_free ? ST_IDLE : ST_HOLD;
      end else begin
         unique case (state_ff)
            ST_INIT: begin
               if (cnt_ff == AddrW'(StoreDepth - 1)) state_in = ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_op)
                     OP_WRITE_XY, OP_READ_XY, OP_READ_STRIP: state_in = ST_READ;
                     OP_CLEAR: state_in = ST_CLEAR;
                     OP_SCROLL_LEFT, OP_SCROLL_RIGHT, OP_SCROLL_UP,
                     OP_SCROLL_DOWN: state_in = ST_SCROLL;
                  endcase
               end
            end
            ST_READ, ST_SCROLL, ST_CLEAR, ST_HOLD: state_in = state_ff;
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) cnt_ff <= '0;
         else if (state_ff == ST_INIT || state_ff == ST_CLEAR) cnt_ff <= cnt_ff + AddrW'(1);
         if (res_valid && slot_free) rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && slot_free) rsp_data_ff <= res;
      if (res_valid && !slot_free) pend_ff <= res;
      else if (accept) pend_ff <= '{mapped_index: read_idx, out_of_range: 1'b0,
                                     pixel_out: '0};
      if (accept) begin
         step_ff <= '0;
         line_ff <= '0;
         vert_ff <= (req_op == OP_SCROLL_UP) || (req_op == OP_SCROLL_DOWN);
         rev_ff  <= (req_op == OP_SCROLL_RIGHT) || (req_op == OP_SCROLL_UP);
      end else if (state_ff == ST_SCROLL) begin
         if (step_last) begin
            step_ff <= '0;
            line_ff <= line_ff + PosW'(1);
         end else begin
            step_ff <= step_ff + StepW'(1);
         end
      end
      if (state_ff == ST_SCROLL && step_ff == StepW'(1)) tmp_ff <= rd_data;
      addr_d1_ff <= scroll_addr;
      addr_d2_ff <= addr_d1_ff;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.mapped_index = rsp_data_ff.mapped_index;
   assign rsp_if.out_of_range = rsp_data_ff.out_of_range;
   assign rsp_if.pixel_out    = rsp_data_ff.pixel_out;
endmodule

### src/led_matrix_frame_store_scroll.sv
`timescale 1ns / 1ps
// Frame store for a 32x32 RGB LED matrix kept in strip order, in one 1024x24
// RAM. After reset the store is swept to black with req_if not ready; CSR
// writes are taken throughout. A request is taken when the block is idle;
// the result of a pixel write, or any out-of-range access, is formed in the
// cycle the request is taken, while a pixel read waits for the RAM's
// registered read data. Clear sweeps W*H entries, one per cycle. A scroll
// rotates each row (or column) through the RAM's read and write ports. One response
// register sits on the rsp side, plus a holding slot when it is stalled.
// Depends on ledfs_pkg, both channel interfaces, ledfs_csr, ledfs_ctrl, ledfs_ram.
module led_matrix_frame_store_scroll (
   input  logic                             clock,
   input  logic                             reset,
   ledfs_req_if.sink                        req_if,
   ledfs_rsp_if.source                      rsp_if,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ledfs_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [ledfs_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [ledfs_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import ledfs_pkg::*;

   cfg_type         cfg;
   ram_cmd_type     ram_cmd;
   logic [PixW-1:0] rd_data;

   ledfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ledfs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .cfg     (cfg),
      .ram_cmd (ram_cmd),
      .rd_data (rd_data)
   );

   ledfs_ram #(
      .Width (PixW),
      .Depth (StoreDepth)
   ) u_pixel_ram (
      .clock   (clock),
      .we      (ram_cmd.we),
      .waddr   (ram_cmd.waddr),
      .wdata   (ram_cmd.wdata),
      .raddr   (ram_cmd.raddr),
      .rd_data (rd_data)
   );
endmodule
